FILE: rtl/cdte_pkg.sv
package cdte_pkg;

  // Field widths
  localparam int YEAR_W   = 15;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 6;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int EPOCH_W  = 40;

  // Calendar constants
  localparam int CYCLE_YEARS        = 400;
  localparam int LEAPS_PER_CYCLE    = 97;
  localparam int LEAPS_BEFORE_EPOCH = 478;
  localparam int EPOCH_YEAR         = 1970;
  localparam int DAYS_PER_YEAR      = 365;
  localparam int SECONDS_PER_DAY    = 86400;

  // Bias that makes every 15-bit year non-negative (a whole number of cycles)
  localparam int CYCLE_BIAS = 42;
  localparam int YEAR_BIAS  = CYCLE_BIAS * CYCLE_YEARS;

  // Reciprocal of 400 in 2^-25 units, rounded down; the estimate is at most one low
  localparam int RECIP_SHIFT = 25;
  localparam int RECIP_400   = (1 << RECIP_SHIFT) / CYCLE_YEARS;

  // Days in the months before the month with index m (month minus one), common year
  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [8:0] d;
    case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/cdte_in_if.sv
interface cdte_in_if;
  import cdte_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [YEAR_W-1:0]   year_value;
  logic [MONTH_W-1:0]         month_value;
  logic [DAY_W-1:0]           day_value;
  logic [HOUR_W-1:0]          hour_value;
  logic [MINUTE_W-1:0]        minute_value;
  logic [SECOND_W-1:0]        second_value;

  modport source (
    output valid, year_value, month_value, day_value, hour_value, minute_value,
           second_value,
    input  ready
  );

  modport sink (
    input  valid, year_value, month_value, day_value, hour_value, minute_value,
           second_value,
    output ready
  );
endinterface

FILE: rtl/cdte_out_if.sv
interface cdte_out_if;
  import cdte_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [EPOCH_W-1:0]  epoch_seconds;
  logic                       time_valid;

  modport source (
    output valid, epoch_seconds, time_valid,
    input  ready
  );

  modport sink (
    input  valid, epoch_seconds, time_valid,
    output ready
  );
endinterface

FILE: rtl/civil_datetime_to_epoch_seconds_core.sv
// channel   | dir | payload                                          | handshake
// ----------+-----+--------------------------------------------------+-------------
// in_chan   | in  | year, month, day, hour, minute, second           | valid/ready
// out_chan  | out | epoch_seconds (40b signed), time_valid           | valid/ready
//
// Four register stages; an accepted beat passes through stages 1 to 4 and shows on out_chan from the stage 4 register.
// One beat enters per cycle while out_chan.ready is high; the 25x17 day-to-second
// multiply in the last stage and the reciprocal divide by 400 in the first set the depth.
// Each stage loads when it is empty or the stage after it moves, so bubbles close up
// and input keeps flowing while a result waits, until all four stages are full.
// rst_n (synchronous) clears only the stage valid bits; payload registers carry no reset.
module civil_datetime_to_epoch_seconds_core (
  input  logic       clk,
  input  logic       rst_n,
  cdte_in_if.sink    in_chan,
  cdte_out_if.source out_chan
);
  import cdte_pkg::*;

  // ---------------------------------------------------------------------------
  // Stage advance: a stage loads when empty or when its successor moves on
  // ---------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r;
  logic ld1, ld2, ld3, ld4;

  assign ld4 = !v4_r || out_chan.ready;
  assign ld3 = !v3_r || ld4;
  assign ld2 = !v2_r || ld3;
  assign ld1 = !v1_r || ld2;

  assign in_chan.ready = ld1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_chan.valid;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
      if (ld4) v4_r <= v3_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: range check, biased year, quotient estimate, hour*60+minute
  // ---------------------------------------------------------------------------
  logic signed [16:0] year_ext;
  logic signed [16:0] year_biased;
  logic [15:0]        ub_nxt;
  logic [32:0]        recip_prod;
  logic [6:0]         qest_nxt;
  logic signed [15:0] ydiff_nxt;
  logic [10:0]        hm_nxt;
  logic               tv1_nxt;

  logic [15:0]        ub_r;
  logic [6:0]         qest_r;
  logic signed [15:0] ydiff_r;
  logic [10:0]        hm_r;
  logic [SECOND_W-1:0] sec1_r;
  logic [MONTH_W-1:0] mon1_r;
  logic [DAY_W-1:0]   day1_r;
  logic               tv1_r;

  always_comb begin
    year_ext    = 17'(in_chan.year_value);
    year_biased = year_ext + 17'(YEAR_BIAS);
    ub_nxt      = year_biased[15:0];
    // floor(ub/400), possibly one low; fixed up in stage 2
    recip_prod  = 33'(ub_nxt) * 33'(RECIP_400);
    qest_nxt    = recip_prod[RECIP_SHIFT +: 7];
    ydiff_nxt   = 16'(year_ext - 17'(EPOCH_YEAR));
    hm_nxt      = 11'(in_chan.hour_value) * 11'd60 + 11'(in_chan.minute_value);
    tv1_nxt     = (in_chan.month_value inside {[4'd1:4'd12]}) &&
                  (in_chan.day_value inside {[6'd1:6'd31]}) &&
                  (in_chan.hour_value <= 5'd23) &&
                  (in_chan.minute_value <= 6'd59) &&
                  (in_chan.second_value <= 6'd60);
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      ub_r    <= ub_nxt;
      qest_r  <= qest_nxt;
      ydiff_r <= ydiff_nxt;
      hm_r    <= hm_nxt;
      sec1_r  <= in_chan.second_value;
      mon1_r  <= in_chan.month_value;
      day1_r  <= in_chan.day_value;
      tv1_r   <= tv1_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: exact cycle and year-in-cycle, whole-year days, seconds of day
  // ---------------------------------------------------------------------------
  logic [15:0]        rem_est;
  logic [6:0]         q_nxt;
  logic [8:0]         rem_nxt;
  logic signed [24:0] yd365_nxt;
  logic [16:0]        hms_nxt;

  logic [6:0]         q_r;
  logic [8:0]         rem_r;
  logic signed [24:0] yd365_r;
  logic [16:0]        hms2_r;
  logic [MONTH_W-1:0] mon2_r;
  logic [DAY_W-1:0]   day2_r;
  logic               tv2_r;

  always_comb begin
    rem_est = ub_r - 16'(qest_r) * 16'(CYCLE_YEARS);
    if (rem_est >= 16'(CYCLE_YEARS)) begin
      q_nxt   = qest_r + 7'd1;
      rem_nxt = 9'(rem_est - 16'(CYCLE_YEARS));
    end else begin
      q_nxt   = qest_r;
      rem_nxt = rem_est[8:0];
    end
    yd365_nxt = 25'(ydiff_r) * 25'sd365;
    hms_nxt   = 17'(hm_r) * 17'd60 + 17'(sec1_r);
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      q_r     <= q_nxt;
      rem_r   <= rem_nxt;
      yd365_r <= yd365_nxt;
      hms2_r  <= hms_nxt;
      mon2_r  <= mon1_r;
      day2_r  <= day1_r;
      tv2_r   <= tv1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: leap rule and day count since the epoch
  // ---------------------------------------------------------------------------
  logic               leap;
  logic [1:0]         centuries;
  logic [6:0]         leaps;
  logic signed [7:0]  cyc;
  logic signed [24:0] days_nxt;
  logic [MONTH_W-1:0] mon_idx;

  logic signed [24:0] days_r;
  logic [16:0]        hms3_r;
  logic               tv3_r;

  always_comb begin
    // a year divisible by 100 leaps only at the start of the cycle
    leap = (rem_r[1:0] == 2'd0) && (rem_r != 9'd100) && (rem_r != 9'd200) &&
           (rem_r != 9'd300);
    if (rem_r >= 9'd300)      centuries = 2'd3;
    else if (rem_r >= 9'd200) centuries = 2'd2;
    else if (rem_r >= 9'd100) centuries = 2'd1;
    else                      centuries = 2'd0;
    // leap years in [cycle start, year)
    leaps    = 7'(!leap) + 7'(rem_r[8:2]) - 7'(centuries);
    cyc      = $signed({1'b0, q_r}) - 8'sd42;
    mon_idx  = mon2_r - 4'd1;
    days_nxt = yd365_r
             + 25'(cyc) * 25'sd97
             + $signed(25'(leaps))
             - 25'sd478
             + $signed(25'(days_before_month(mon_idx)))
             + $signed(25'(leap && (mon2_r > 4'd2)))
             + $signed(25'(day2_r))
             - 25'sd1;
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      days_r <= days_nxt;
      hms3_r <= hms2_r;
      tv3_r  <= tv2_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: scale days to seconds, add time of day, drop to zero when invalid
  // ---------------------------------------------------------------------------
  logic signed [41:0]        total;
  logic signed [EPOCH_W-1:0] epoch_nxt;

  logic signed [EPOCH_W-1:0] epoch_r;
  logic                      tv4_r;

  always_comb begin
    total     = 42'(days_r) * 42'sd86400 + $signed(42'(hms3_r));
    epoch_nxt = tv3_r ? total[EPOCH_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (ld4) begin
      epoch_r <= epoch_nxt;
      tv4_r   <= tv3_r;
    end
  end

  assign out_chan.valid         = v4_r;
  assign out_chan.epoch_seconds = epoch_r;
  assign out_chan.time_valid    = tv4_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.time_valid) |-> (out_chan.epoch_seconds == '0))
    else $error("invalid result carries nonzero seconds");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> v1_r)
    else $error("accepted beat did not enter stage 1");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && v4_r && !out_chan.ready) |-> !in_chan.ready)
    else $error("full stalled pipeline still takes input");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (rem_r < 9'd400))
    else $error("year-in-cycle out of range");

endmodule

FILE: tb/cdte_epoch_checker.sv
module cdte_epoch_checker (
  input  logic clk,
  input  logic rst_n,
  cdte_in_if   in_mon,
  cdte_out_if  out_mon,
  output int   fail_count,
  output int   pending_beats
);
  timeunit 1ns;
  timeprecision 1ps;
  import cdte_pkg::*;

  typedef struct packed {
    logic signed [EPOCH_W-1:0] secs;
    logic                      tv;
  } epoch_result_t;

  // Days elapsed before the first of each month in a common year
  localparam int MONTH_START_DAY [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  epoch_result_t epoch_q[$];
  int            mismatches = 0;
  int            queued     = 0;

  assign fail_count    = mismatches;
  assign pending_beats = queued;

  function automatic epoch_result_t predict_epoch(
    input logic signed [YEAR_W-1:0] yr,
    input logic [MONTH_W-1:0]       mon,
    input logic [DAY_W-1:0]         day,
    input logic [HOUR_W-1:0]        hr,
    input logic [MINUTE_W-1:0]      mn,
    input logic [SECOND_W-1:0]      sc
  );
    epoch_result_t r;
    longint        y, cyc, rem, days, total;
    bit            leap;
    r = '0;
    if (mon < 1 || mon > 12 || day < 1 || day > 31 || hr > 23 || mn > 59 || sc > 60)
      return r;
    y   = yr;
    // floor the cycle index so negative years land in the right cycle
    cyc = y / CYCLE_YEARS;
    rem = y % CYCLE_YEARS;
    if (rem < 0) begin
      cyc = cyc - 1;
      rem = rem + CYCLE_YEARS;
    end
    leap = ((rem % 4 == 0) && (rem % 100 != 0)) || (rem == 0);
    days = (y - EPOCH_YEAR) * DAYS_PER_YEAR + cyc * LEAPS_PER_CYCLE
           + (leap ? 0 : 1) + rem / 4 - rem / 100 - LEAPS_BEFORE_EPOCH;
    days = days + MONTH_START_DAY[int'(mon) - 1];
    if (leap && mon > 2)
      days = days + 1;
    days  = days + longint'(day) - 1;
    total = days * SECONDS_PER_DAY
            + (longint'(hr) * 60 + longint'(mn)) * 60 + longint'(sc);
    r.secs = total[EPOCH_W-1:0];
    r.tv   = 1'b1;
    return r;
  endfunction

  // Print one line per mismatch and count it
  task automatic flag_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    epoch_result_t got, want;
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        got.secs = out_mon.epoch_seconds;
        got.tv   = out_mon.time_valid;
        if (epoch_q.size() == 0) begin
          flag_mismatch($sformatf("result beat with nothing pending: secs=%0d valid=%0b",
                                  got.secs, got.tv));
        end else begin
          want = epoch_q.pop_front();
          if (got.secs !== want.secs)
            flag_mismatch($sformatf("epoch_seconds got %0d want %0d", got.secs, want.secs));
          if (got.tv !== want.tv)
            flag_mismatch($sformatf("time_valid got %0b want %0b", got.tv, want.tv));
        end
      end
      if (in_mon.valid && in_mon.ready)
        epoch_q.push_back(predict_epoch(in_mon.year_value, in_mon.month_value,
                                        in_mon.day_value, in_mon.hour_value,
                                        in_mon.minute_value, in_mon.second_value));
      queued <= epoch_q.size();
    end
  end

endmodule

FILE: tb/tb_civil_datetime_to_epoch_seconds_core.sv
module tb_civil_datetime_to_epoch_seconds_core;
  timeunit 1ns;
  timeprecision 1ps;

  // Generous ceiling, far above what a healthy run needs
  localparam int RUN_LIMIT     = 300000;
  // Pipeline is four stages deep; leave room past that for stray beats
  localparam int DRAIN_CYCLES  = 16;
  localparam int RANDOM_STAMPS = 1400;

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_count = 0;
  int   checker_fails;
  int   checker_pending;
  bit   sender_calm = 1'b1;

  cdte_in_if  in_bus ();
  cdte_out_if out_bus ();

  civil_datetime_to_epoch_seconds_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  cdte_epoch_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_bus),
    .out_mon       (out_bus),
    .fail_count    (checker_fails),
    .pending_beats (checker_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: count cycles and abort a hung run
  initial begin
    forever begin
      @(posedge clk);
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Result side: stall on about ten percent of cycles, but hold ready solid through
  // a long window so back-to-back beats also get exercised
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (cycle_count >= 400 && cycle_count < 900)
        out_bus.ready <= 1'b1;
      else
        out_bus.ready <= ($urandom_range(0, 99) >= 10);
    end
  end

  // Present one timestamp and hold it until the block takes the beat.
  // Afterwards maybe drop valid for a short random gap; when no gap is taken,
  // the next call raises valid again in the same step, so valid stays high.
  task automatic send_stamp(input int y, input int mo, input int d,
                            input int h, input int mi, input int s);
    in_bus.valid        <= 1'b1;
    in_bus.year_value   <= y[14:0];
    in_bus.month_value  <= mo[3:0];
    in_bus.day_value    <= d[5:0];
    in_bus.hour_value   <= h[4:0];
    in_bus.minute_value <= mi[5:0];
    in_bus.second_value <= s[5:0];
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    if (!sender_calm && $urandom_range(0, 99) < 10) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  // Drop valid and wait until the checker has nothing outstanding.
  // Wait on a clock edge first so the last accepted beat is counted.
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (checker_pending != 0) @(posedge clk);
  endtask

  // Mostly well-formed stamps with random content, some with one field
  // pushed out of range, and some raw noise over the full field widths
  task automatic send_random_stamp();
    int y, mo, d, h, mi, s, pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 1) == 1)
      y = int'($urandom_range(0, 19998)) - 9999;
    else
      y = $urandom_range(0, 32767);
    mo = $urandom_range(1, 12);
    d  = ($urandom_range(0, 3) == 0) ? $urandom_range(28, 31) : $urandom_range(1, 31);
    h  = $urandom_range(0, 23);
    mi = $urandom_range(0, 59);
    s  = ($urandom_range(0, 15) == 0) ? 60 : $urandom_range(0, 60);
    if (pick >= 80 && pick < 90) begin
      // break exactly one field
      case ($urandom_range(0, 4))
        0:       mo = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(13, 15);
        1:       d  = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(32, 63);
        2:       h  = $urandom_range(24, 31);
        3:       mi = $urandom_range(60, 63);
        default: s  = $urandom_range(61, 63);
      endcase
    end else if (pick >= 90) begin
      mo = $urandom_range(0, 15);
      d  = $urandom_range(0, 63);
      h  = $urandom_range(0, 31);
      mi = $urandom_range(0, 63);
      s  = $urandom_range(0, 63);
    end
    send_stamp(y, mo, d, h, mi, s);
  endtask

  initial begin
    rst_n               <= 1'b0;
    in_bus.valid        <= 1'b0;
    in_bus.year_value   <= '0;
    in_bus.month_value  <= '0;
    in_bus.day_value    <= '0;
    in_bus.hour_value   <= '0;
    in_bus.minute_value <= '0;
    in_bus.second_value <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: epoch itself and one second before it
    send_stamp(1970, 1, 1, 0, 0, 0);
    send_stamp(1969, 12, 31, 23, 59, 59);
    // Leap rules: divisible by 400, by 100 only, by 4, and year 0
    send_stamp(2000, 2, 29, 12, 30, 30);
    send_stamp(2000, 3, 1, 0, 0, 0);
    send_stamp(1900, 3, 1, 0, 0, 0);
    send_stamp(2024, 12, 31, 23, 59, 60);
    send_stamp(0, 3, 1, 0, 0, 0);
    // Negative years across cycle boundaries
    send_stamp(-1, 12, 31, 23, 59, 59);
    send_stamp(-400, 1, 1, 0, 0, 0);
    send_stamp(-401, 3, 1, 1, 2, 3);
    // Extremes of the nominal range and of the 15-bit field (the most negative year wraps past 40 bits)
    send_stamp(9999, 12, 31, 23, 59, 60);
    send_stamp(-9999, 1, 1, 0, 0, 0);
    send_stamp(16383, 12, 31, 23, 59, 60);
    send_stamp(-16384, 1, 1, 0, 0, 0);
    // Day past the end of a 30-day month rolls into the next month
    send_stamp(2023, 4, 31, 8, 0, 0);
    // Every out-of-range field, at its first bad value and at all ones
    send_stamp(2020, 0, 10, 0, 0, 0);
    send_stamp(2020, 13, 10, 0, 0, 0);
    send_stamp(2020, 15, 10, 0, 0, 0);
    send_stamp(2020, 6, 0, 0, 0, 0);
    send_stamp(2020, 6, 32, 0, 0, 0);
    send_stamp(2020, 6, 63, 31, 63, 63);
    send_stamp(2020, 6, 10, 24, 0, 0);
    send_stamp(2020, 6, 10, 0, 60, 0);
    send_stamp(2020, 6, 10, 0, 63, 0);
    send_stamp(2020, 6, 10, 0, 0, 61);

    sender_calm = 1'b0;
    for (int i = 0; i < RANDOM_STAMPS; i++) begin
      // back-to-back stretch with no sender gaps
      sender_calm = (i >= 300 && i < 700);
      // let the pipeline empty completely once mid-run
      if (i == 900)
        wait_drained();
      send_random_stamp();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (checker_fails == 0 && checker_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
